/* src/iau_pkg.sv */
// ----------------------------------------------------------------------------
// iau_pkg
// shared widths, operation and error codes, and the pipeline stage record
// ----------------------------------------------------------------------------
package iau_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FUNC_WIDTH = 3;
  localparam int ERR_WIDTH  = 2;
  localparam int NUM_STEPS  = DATA_WIDTH;

  typedef enum logic [FUNC_WIDTH-1:0] {
    FN_ADD  = 3'd0,
    FN_SUB  = 3'd1,
    FN_MUL  = 3'd2,
    FN_DIV  = 3'd3,
    FN_MOD  = 3'd4,
    FN_POW  = 3'd5,
    FN_NOP6 = 3'd6,
    FN_NOP7 = 3'd7
  } func_t;

  typedef enum logic [ERR_WIDTH-1:0] {
    ERR_NONE   = 2'd0,
    ERR_DIV0   = 2'd1,
    ERR_NEGEXP = 2'd2,
    ERR_RSVD   = 2'd3
  } err_t;

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef struct packed {
    logic  vld;
    func_t func;
    err_t  err;
    word_t simple;
    logic  neg_q;
    logic  neg_r;
    word_t rem;
    word_t quo;
    word_t divisor;
    word_t acc;
    word_t sq;
    word_t expo;
  } stage_t;

endpackage

/* src/iau_if.sv */
// ----------------------------------------------------------------------------
// iau_in_if / iau_out_if
// valid/ready channels for operand beats and result beats
// ----------------------------------------------------------------------------
interface iau_in_if;
  logic                            valid;
  logic                            ready;
  logic [iau_pkg::DATA_WIDTH-1:0]  operand_a;
  logic [iau_pkg::DATA_WIDTH-1:0]  operand_b;
  logic [iau_pkg::FUNC_WIDTH-1:0]  func;
  modport source (output valid, operand_a, operand_b, func, input ready);
  modport sink   (input valid, operand_a, operand_b, func, output ready);
endinterface

interface iau_out_if;
  logic                            valid;
  logic                            ready;
  logic [iau_pkg::DATA_WIDTH-1:0]  result;
  logic [iau_pkg::ERR_WIDTH-1:0]   error;
  modport source (output valid, result, error, input ready);
  modport sink   (input valid, result, error, output ready);
endinterface

/* src/integer_arithmetic_unit_core.sv */
// ----------------------------------------------------------------------------
// integer_arithmetic_unit_core
// 32-bit signed add, sub, mul, div, mod and power unit
// ----------------------------------------------------------------------------
// usage:
//   in_bus carries operand_a, operand_b and func; a beat moves when valid and
//   ready are high at a rising edge. out_bus returns result and error.
//   the pipeline has one entry stage, one stage per quotient bit / exponent
//   bit and one output register stage.
//   throughput is one beat per cycle while the output is not stalled; every
//   beat passes all stages whatever its func.
//   when out_bus.ready is low with a result waiting, the whole pipeline
//   holds and in_bus.ready drops; nothing is lost or repeated.
//   synchronous active-low reset clears all valid bits; the pipeline is
//   empty and in_bus.ready is high after reset.
//   divide or mod by zero gives 0 with error 1; negative exponent gives 0
//   with error 2; func 6 and 7 give 0.
// ----------------------------------------------------------------------------
module integer_arithmetic_unit_core (
  input  logic       clk,
  input  logic       rst_n,
  iau_in_if.sink     in_bus,
  iau_out_if.source  out_bus
);
  localparam int N = iau_pkg::NUM_STEPS;

  logic            adv;
  logic            out_vld;
  iau_pkg::stage_t st [N+1];

  assign adv          = !out_vld || out_bus.ready;
  assign in_bus.ready = adv;
  assign out_bus.valid = out_vld;

  iau_prep u_prep (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vld   (in_bus.valid),
    .a     (in_bus.operand_a),
    .b     (in_bus.operand_b),
    .fn    (in_bus.func),
    .st_r  (st[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_step
    iau_step u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .st_in (st[i]),
      .st_r  (st[i+1])
    );
  end

  iau_post u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .st_in    (st[N]),
    .vld_r    (out_vld),
    .result_r (out_bus.result),
    .error_r  (out_bus.error)
  );
endmodule

/* src/iau_prep.sv */
// ----------------------------------------------------------------------------
// iau_prep
// entry stage: add, sub, mul, magnitudes, signs and error detection
// ----------------------------------------------------------------------------
module iau_prep (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           vld,
  input  logic [iau_pkg::DATA_WIDTH-1:0] a,
  input  logic [iau_pkg::DATA_WIDTH-1:0] b,
  input  logic [iau_pkg::FUNC_WIDTH-1:0] fn,
  output iau_pkg::stage_t                st_r
);
  localparam int W = iau_pkg::DATA_WIDTH;

  iau_pkg::stage_t st_nxt;
  logic            a_neg;
  logic            b_neg;
  logic [W-1:0]    prod;

  assign a_neg = a[W-1];
  assign b_neg = b[W-1];
  assign prod  = a * b;

  always_comb begin
    st_nxt         = '0;
    st_nxt.vld     = vld;
    st_nxt.func    = iau_pkg::func_t'(fn);
    st_nxt.err     = iau_pkg::ERR_NONE;
    st_nxt.neg_q   = a_neg ^ b_neg;
    st_nxt.neg_r   = a_neg;
    st_nxt.rem     = '0;
    st_nxt.quo     = a_neg ? (~a + W'(1)) : a;
    st_nxt.divisor = b_neg ? (~b + W'(1)) : b;
    st_nxt.acc     = W'(1);
    st_nxt.sq      = a;
    st_nxt.expo    = b;
    unique case (iau_pkg::func_t'(fn))
      iau_pkg::FN_ADD: st_nxt.simple = a + b;
      iau_pkg::FN_SUB: st_nxt.simple = a - b;
      iau_pkg::FN_MUL: st_nxt.simple = prod;
      iau_pkg::FN_DIV, iau_pkg::FN_MOD: begin
        if (b == '0) st_nxt.err = iau_pkg::ERR_DIV0;
      end
      iau_pkg::FN_POW: begin
        if (b_neg) begin
          st_nxt.err  = iau_pkg::ERR_NEGEXP;
          st_nxt.expo = '0;
        end
      end
      default: st_nxt.simple = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.vld <= 1'b0;
    end else if (en) begin
      st_r.vld <= st_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r.func    <= st_nxt.func;
      st_r.err     <= st_nxt.err;
      st_r.simple  <= st_nxt.simple;
      st_r.neg_q   <= st_nxt.neg_q;
      st_r.neg_r   <= st_nxt.neg_r;
      st_r.rem     <= st_nxt.rem;
      st_r.quo     <= st_nxt.quo;
      st_r.divisor <= st_nxt.divisor;
      st_r.acc     <= st_nxt.acc;
      st_r.sq      <= st_nxt.sq;
      st_r.expo    <= st_nxt.expo;
    end
  end
endmodule

/* src/iau_step.sv */
// ----------------------------------------------------------------------------
// iau_step
// one pipeline stage: one restoring divide bit and one square-and-multiply bit
// ----------------------------------------------------------------------------
module iau_step (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  iau_pkg::stage_t st_in,
  output iau_pkg::stage_t st_r
);
  localparam int W = iau_pkg::DATA_WIDTH;

  iau_pkg::stage_t st_nxt;
  logic [W:0]      rem_sh;
  logic [W:0]      diff;
  logic [W-1:0]    acc_mul;
  logic [W-1:0]    sq_mul;

  assign rem_sh  = {st_in.rem, st_in.quo[W-1]};
  assign diff    = rem_sh - {1'b0, st_in.divisor};
  assign acc_mul = st_in.acc * st_in.sq;
  assign sq_mul  = st_in.sq * st_in.sq;

  always_comb begin
    st_nxt      = st_in;
    // divide: msb first
    st_nxt.rem  = diff[W] ? rem_sh[W-1:0] : diff[W-1:0];
    st_nxt.quo  = {st_in.quo[W-2:0], ~diff[W]};
    // power: exponent lsb first
    st_nxt.acc  = st_in.expo[0] ? acc_mul : st_in.acc;
    st_nxt.sq   = sq_mul;
    st_nxt.expo = {1'b0, st_in.expo[W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.vld <= 1'b0;
    end else if (en) begin
      st_r.vld <= st_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r.func    <= st_nxt.func;
      st_r.err     <= st_nxt.err;
      st_r.simple  <= st_nxt.simple;
      st_r.neg_q   <= st_nxt.neg_q;
      st_r.neg_r   <= st_nxt.neg_r;
      st_r.rem     <= st_nxt.rem;
      st_r.quo     <= st_nxt.quo;
      st_r.divisor <= st_nxt.divisor;
      st_r.acc     <= st_nxt.acc;
      st_r.sq      <= st_nxt.sq;
      st_r.expo    <= st_nxt.expo;
    end
  end
endmodule

/* src/iau_post.sv */
// ----------------------------------------------------------------------------
// iau_post
// output stage: sign correction, result select and output register
// ----------------------------------------------------------------------------
module iau_post (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  iau_pkg::stage_t                st_in,
  output logic                           vld_r,
  output logic [iau_pkg::DATA_WIDTH-1:0] result_r,
  output logic [iau_pkg::ERR_WIDTH-1:0]  error_r
);
  localparam int W = iau_pkg::DATA_WIDTH;

  logic [W-1:0] result_nxt;
  logic [W-1:0] q_fix;
  logic [W-1:0] r_fix;

  assign q_fix = st_in.neg_q ? (~st_in.quo + W'(1)) : st_in.quo;
  assign r_fix = st_in.neg_r ? (~st_in.rem + W'(1)) : st_in.rem;

  always_comb begin
    result_nxt = '0;
    if (st_in.err == iau_pkg::ERR_NONE) begin
      unique case (st_in.func)
        iau_pkg::FN_ADD, iau_pkg::FN_SUB, iau_pkg::FN_MUL: result_nxt = st_in.simple;
        iau_pkg::FN_DIV: result_nxt = q_fix;
        iau_pkg::FN_MOD: result_nxt = r_fix;
        iau_pkg::FN_POW: result_nxt = st_in.acc;
        default:         result_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= st_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_r <= result_nxt;
      error_r  <= st_in.err;
    end
  end
endmodule

/* src/iau_checker.sv */
// ----------------------------------------------------------------------------
// iau_checker
// port-level checks on the arithmetic unit, bound to the top level
// ----------------------------------------------------------------------------
module iau_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [iau_pkg::DATA_WIDTH-1:0] out_result,
  input logic [iau_pkg::ERR_WIDTH-1:0]  out_error
);
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_error != iau_pkg::ERR_RSVD)
    else $error("reserved error code");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error != iau_pkg::ERR_NONE) |-> out_result == '0)
    else $error("error beat with nonzero result");

  a_no_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled without output backpressure");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_result) && $stable(out_error)))
    else $error("stalled result beat changed");
endmodule

bind integer_arithmetic_unit_core iau_checker u_iau_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_bus.ready),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .out_result (out_bus.result),
  .out_error  (out_bus.error)
);
